[rtl/radix_histogram_partition_top_assert.svh]
// ----------------------------------------------------------------------------
// radix_histogram_partition_top_assert.svh
// Assertion macros shared by the radix partitioner RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX_HISTOGRAM_PARTITION_TOP_ASSERT_SVH
`define RADIX_HISTOGRAM_PARTITION_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define RHP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rhp_pkg.sv]
// ----------------------------------------------------------------------------
// rhp_pkg
// Types and constants of the radix histogram partitioner.
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned PAY_W      = 32;
  localparam int unsigned DEST_W     = 15;
  localparam int unsigned BKT_W      = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned PAD_W      = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned Q_DEPTH    = 4;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EMIT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // register select, paddr[2]
  localparam logic REG_SHIFT = 1'b0;
  localparam logic REG_PAD   = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_DROP,
    CMD_EMPTY,
    CMD_FIRST,
    CMD_EMIT
  } rhp_cmd_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LD_WR,
    S_PFX,
    S_EM_T,
    S_EM_S
  } rhp_state_e;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [PAD_W-1:0]   pad;
  } rhp_cfg_t;

  typedef struct packed {
    logic init_done;
  } rhp_stat_t;

  // radix field before masking: (key - 1) >> shift, key - 1 wraps
  function automatic logic [KEY_W-1:0] radix_field(input logic [KEY_W-1:0]   key,
                                                   input logic [SHIFT_W-1:0] shift);
    return (key - KEY_W'(1)) >> shift;
  endfunction

endpackage

[rtl/rhp_req_if.sv]
// ----------------------------------------------------------------------------
// rhp_req_if
// Request channel: load or emit, with key and payload.
// ----------------------------------------------------------------------------
interface rhp_req_if import rhp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, req_type, key, payload, input ready);
  modport sink   (input valid, req_type, key, payload, output ready);
endinterface

[rtl/rhp_rsp_if.sv]
// ----------------------------------------------------------------------------
// rhp_rsp_if
// Result channel: status and placed tuple.
// ----------------------------------------------------------------------------
interface rhp_rsp_if import rhp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [PAY_W-1:0]    out_payload;
  logic [DEST_W-1:0]   dest_index;
  logic [BKT_W-1:0]    bucket;
  logic                last;

  modport source (output valid, status, out_key, out_payload, dest_index, bucket, last,
                  input ready);
  modport sink   (input valid, status, out_key, out_payload, dest_index, bucket, last,
                  output ready);
endinterface

[rtl/rhp_ram.sv]
// ----------------------------------------------------------------------------
// rhp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rhp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rhp_fifo.sv]
// ----------------------------------------------------------------------------
// rhp_fifo
// Short command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
`include "radix_histogram_partition_top_assert.svh"

module rhp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNTW'(1);
      2'b01:   cnt_d = cnt_q - CNTW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `RHP_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "queue push while full")
  `RHP_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNTW'(DEPTH), "queue count out of range")

endmodule

[rtl/rhp_front.sv]
// ----------------------------------------------------------------------------
// rhp_front
// Request classifier: tracks batch fill and emit order, queues commands.
// ----------------------------------------------------------------------------
module rhp_front import rhp_pkg::*; #(
  parameter int unsigned MAX_TUPLES = 1024,
  localparam int unsigned AW = $clog2(MAX_TUPLES),
  localparam int unsigned CW = $clog2(MAX_TUPLES + 1),
  localparam int unsigned EW = $bits(rhp_cmd_e) + 1 + AW + KEY_W + PAY_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rhp_req_if.sink       req,
  input  rhp_stat_t     stat_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output logic [EW-1:0] q_data_o
);

  typedef struct packed {
    rhp_cmd_e         cmd;
    logic             last;
    logic [AW-1:0]    idx;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  entry_t        ent;
  logic          accept;
  logic [CW-1:0] stored_q, stored_d;
  logic [CW-1:0] rp_q, rp_d, rp_cur;
  logic          phase_q, phase_d;
  logic          is_last;

  assign req.ready = !q_full_i && stat_i.init_done;
  assign accept    = req.valid && req.ready;
  assign q_push_o  = accept;
  assign q_data_o  = ent;

  always_comb begin
    stored_d    = stored_q;
    phase_d     = phase_q;
    rp_d        = rp_q;
    rp_cur      = phase_q ? rp_q : '0;
    is_last     = (rp_cur + CW'(1)) >= stored_q;
    ent.cmd     = CMD_DROP;
    ent.last    = 1'b0;
    ent.idx     = stored_q[AW-1:0];
    ent.key     = req.key;
    ent.payload = req.payload;
    if (req.req_type == REQ_LOAD) begin
      // loads are dropped once a batch has started emitting or the store is full
      if (!phase_q && (stored_q < CW'(MAX_TUPLES))) begin
        ent.cmd = CMD_LOAD;
        if (accept) begin
          stored_d = stored_q + CW'(1);
        end
      end
    end else if (stored_q == '0) begin
      ent.cmd = CMD_EMPTY;
    end else begin
      ent.cmd  = phase_q ? CMD_EMIT : CMD_FIRST;
      ent.last = is_last;
      ent.idx  = rp_cur[AW-1:0];
      if (accept) begin
        if (is_last) begin
          stored_d = '0;
          phase_d  = 1'b0;
          rp_d     = '0;
        end else begin
          phase_d = 1'b1;
          rp_d    = rp_cur + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      phase_q  <= 1'b0;
      rp_q     <= '0;
    end else begin
      stored_q <= stored_d;
      phase_q  <= phase_d;
      rp_q     <= rp_d;
    end
  end

endmodule

[rtl/rhp_back.sv]
// ----------------------------------------------------------------------------
// rhp_back
// Command executor: tuple store, bucket histogram, prefix pass, scatter.
// ----------------------------------------------------------------------------
`include "radix_histogram_partition_top_assert.svh"

module rhp_back import rhp_pkg::*; #(
  parameter int unsigned RADIX_BITS = 6,
  parameter int unsigned MAX_TUPLES = 1024,
  localparam int unsigned AW = $clog2(MAX_TUPLES),
  localparam int unsigned EW = $bits(rhp_cmd_e) + 1 + AW + KEY_W + PAY_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rhp_cfg_t      cfg_i,
  output rhp_stat_t     stat_o,
  input  logic          q_empty_i,
  input  logic [EW-1:0] q_data_i,
  output logic          q_pop_o,
  rhp_rsp_if.source     rsp
);

  localparam int unsigned FANOUT = 1 << RADIX_BITS;
  localparam int unsigned CW     = $clog2(MAX_TUPLES + 1);
  localparam int unsigned PCW    = RADIX_BITS + 1;
  localparam int unsigned TW     = KEY_W + PAY_W;

  typedef struct packed {
    rhp_cmd_e         cmd;
    logic             last;
    logic [AW-1:0]    idx;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  entry_t                  head;
  rhp_state_e              state_q, state_d;
  logic [PCW-1:0]          pc_q, pc_d, pc_prev;
  logic [RADIX_BITS-1:0]   bkt_q, bkt_d, head_bkt, t_bkt;
  logic                    last_q, last_d;
  logic [DEST_W-1:0]       sum_q, sum_d, padacc_q, padacc_d;
  logic                    can_push;

  // RAM ports
  logic                    t_we, t_re;
  logic [AW-1:0]           t_waddr, t_raddr;
  logic [TW-1:0]           t_wdata, t_rdata;
  logic                    c_we, c_re;
  logic [RADIX_BITS-1:0]   c_waddr, c_raddr;
  logic [CW-1:0]           c_wdata, c_rdata;
  logic                    s_we, s_re;
  logic [RADIX_BITS-1:0]   s_waddr, s_raddr;
  logic [DEST_W-1:0]       s_wdata, s_rdata;

  // result register
  logic                    push;
  logic [STATUS_W-1:0]     p_status;
  logic [KEY_W-1:0]        p_key;
  logic [PAY_W-1:0]        p_pay;
  logic [DEST_W-1:0]       p_dest;
  logic [BKT_W-1:0]        p_bkt;
  logic                    p_last;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [KEY_W-1:0]        out_key_q;
  logic [PAY_W-1:0]        out_pay_q;
  logic [DEST_W-1:0]       out_dest_q;
  logic [BKT_W-1:0]        out_bkt_q;
  logic                    out_last_q;

  assign head     = entry_t'(q_data_i);
  assign head_bkt = RADIX_BITS'(radix_field(head.key, cfg_i.shift));
  assign t_bkt    = RADIX_BITS'(radix_field(t_rdata[TW-1:PAY_W], cfg_i.shift));
  assign pc_prev  = pc_q - PCW'(1);
  assign can_push = !out_valid_q || rsp.ready;
  assign stat_o.init_done = (state_q != S_CLR);

  rhp_ram #(.WIDTH(TW), .DEPTH(MAX_TUPLES)) u_tuple_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  rhp_ram #(.WIDTH(CW), .DEPTH(FANOUT)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  rhp_ram #(.WIDTH(DEST_W), .DEPTH(FANOUT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR: begin
        if (pc_q == PCW'(FANOUT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          unique case (head.cmd) inside
            CMD_LOAD:  state_d = S_LD_WR;
            CMD_FIRST: state_d = S_PFX;
            CMD_EMIT:  state_d = S_EM_T;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_LD_WR: begin
        if (can_push) begin
          state_d = S_IDLE;
        end
      end
      S_PFX: begin
        if (pc_q == PCW'(FANOUT)) begin
          state_d = S_EM_T;
        end
      end
      S_EM_T:  state_d = S_EM_S;
      S_EM_S: begin
        if (can_push) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    pc_d     = pc_q;
    bkt_d    = bkt_q;
    last_d   = last_q;
    sum_d    = sum_q;
    padacc_d = padacc_q;
    q_pop_o  = 1'b0;
    t_we     = 1'b0;
    t_waddr  = head.idx;
    t_wdata  = {head.key, head.payload};
    t_re     = 1'b0;
    t_raddr  = head.idx;
    c_we     = 1'b0;
    c_waddr  = bkt_q;
    c_wdata  = '0;
    c_re     = 1'b0;
    c_raddr  = head_bkt;
    s_we     = 1'b0;
    s_waddr  = bkt_q;
    s_wdata  = s_rdata + DEST_W'(1);
    s_re     = 1'b0;
    s_raddr  = t_bkt;
    push     = 1'b0;
    p_status = ST_LOADED;
    p_key    = '0;
    p_pay    = '0;
    p_dest   = '0;
    p_bkt    = '0;
    p_last   = 1'b0;
    unique case (state_q)
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = pc_q[RADIX_BITS-1:0];
        pc_d    = (pc_q == PCW'(FANOUT - 1)) ? '0 : pc_q + PCW'(1);
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          unique case (head.cmd) inside
            CMD_LOAD: begin
              q_pop_o = 1'b1;
              t_we    = 1'b1;
              c_re    = 1'b1;
              bkt_d   = head_bkt;
            end
            CMD_FIRST: begin
              q_pop_o  = 1'b1;
              t_re     = 1'b1;
              last_d   = head.last;
              pc_d     = '0;
              sum_d    = '0;
              padacc_d = '0;
            end
            CMD_EMIT: begin
              q_pop_o = 1'b1;
              t_re    = 1'b1;
              last_d  = head.last;
            end
            CMD_DROP, CMD_EMPTY: begin
              if (can_push) begin
                q_pop_o  = 1'b1;
                push     = 1'b1;
                p_status = (head.cmd == CMD_DROP) ? ST_DROPPED : ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_WR: begin
        if (can_push) begin
          c_we     = 1'b1;
          c_wdata  = c_rdata + CW'(1);
          push     = 1'b1;
          p_status = ST_LOADED;
        end
      end
      S_PFX: begin
        // read count[pc] while count[pc-1] turns into its slot offset and clears
        if (pc_q != PCW'(FANOUT)) begin
          c_re    = 1'b1;
          c_raddr = pc_q[RADIX_BITS-1:0];
        end
        if (pc_q != '0) begin
          c_we     = 1'b1;
          c_waddr  = pc_prev[RADIX_BITS-1:0];
          s_we     = 1'b1;
          s_waddr  = pc_prev[RADIX_BITS-1:0];
          s_wdata  = sum_q + padacc_q;
          sum_d    = sum_q + DEST_W'(c_rdata);
          padacc_d = padacc_q + DEST_W'(cfg_i.pad);
        end
        pc_d = pc_q + PCW'(1);
      end
      S_EM_T: begin
        s_re  = 1'b1;
        bkt_d = t_bkt;
      end
      S_EM_S: begin
        if (can_push) begin
          s_we     = 1'b1;
          push     = 1'b1;
          p_status = ST_PLACED;
          p_key    = t_rdata[TW-1:PAY_W];
          p_pay    = t_rdata[PAY_W-1:0];
          p_dest   = s_rdata;
          p_bkt    = BKT_W'(bkt_q);
          p_last   = last_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bkt_q    <= bkt_d;
    last_q   <= last_d;
    sum_q    <= sum_d;
    padacc_q <= padacc_d;
    if (push) begin
      out_status_q <= p_status;
      out_key_q    <= p_key;
      out_pay_q    <= p_pay;
      out_dest_q   <= p_dest;
      out_bkt_q    <= p_bkt;
      out_last_q   <= p_last;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.out_key     = out_key_q;
  assign rsp.out_payload = out_pay_q;
  assign rsp.dest_index  = out_dest_q;
  assign rsp.bucket      = out_bkt_q;
  assign rsp.last        = out_last_q;

  `RHP_ASSERT_IMPL(a_no_overwrite, out_valid_q && !rsp.ready, !push, "result overwritten")
  `RHP_ASSERT_IMPL(a_pop_nonempty, q_pop_o, !q_empty_i, "pop from empty queue")
  `RHP_ASSERT_NEXT(a_pfx_exit, (state_q == S_PFX) && (pc_q == PCW'(FANOUT)), state_q == S_EM_T, "prefix pass did not hand over to emit")

endmodule

[rtl/radix_histogram_partition_top.sv]
// ----------------------------------------------------------------------------
// radix_histogram_partition_top
// Histogram-based radix partitioner, single partitioner.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries load (req_type 0) and emit (req_type 1) transactions, rsp_o
//   returns exactly one result transaction per request, in request order.
//   APB registers: 0x0 shift_bits, 0x4 partition_padding; write only while idle.
//   Accepted requests enter a 4-entry command queue; the executor behind it
//   takes a load as a tuple RAM write with a bucket-count read, then a count
//   write-back; an emit as a tuple RAM read, then a slot RAM read-modify-write;
//   dropped loads and empty emits are answered directly from idle. Every result
//   is registered before it drives rsp_o.valid.
//   The first emit of a batch adds a prefix pass over the bucket-count RAM,
//   which also clears the counts for the next batch.
//   After reset a clearing pass zeroes the count RAM; req_i.ready stays low
//   until it is done.
//   A stalled rsp_o holds its result; the queue keeps accepting until it fills,
//   then req_i.ready drops.
// ----------------------------------------------------------------------------
module radix_histogram_partition_top import rhp_pkg::*; #(
  parameter int unsigned RADIX_BITS = 6,
  parameter int unsigned MAX_TUPLES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  rhp_req_if.sink               req_i,
  rhp_rsp_if.source             rsp_o
);

  localparam int unsigned AW = $clog2(MAX_TUPLES);
  localparam int unsigned EW = $bits(rhp_cmd_e) + 1 + AW + KEY_W + PAY_W;

  logic [SHIFT_W-1:0] shift_q;
  logic [PAD_W-1:0]   pad_q;
  logic               cfg_wr;
  rhp_cfg_t           cfg;
  rhp_stat_t          stat;
  logic               q_push, q_full, q_pop, q_empty;
  logic [EW-1:0]      q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      pad_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SHIFT: shift_q <= pwdata[SHIFT_W-1:0];
        REG_PAD:   pad_q   <= pwdata[PAD_W-1:0];
        default:   ;
      endcase
    end
  end

  assign prdata    = (paddr[2] == REG_PAD) ? CFG_DATA_W'(pad_q) : CFG_DATA_W'(shift_q);
  assign cfg.shift = shift_q;
  assign cfg.pad   = pad_q;

  rhp_front #(.MAX_TUPLES(MAX_TUPLES)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .stat_i   (stat),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  rhp_fifo #(.WIDTH(EW), .DEPTH(Q_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  rhp_back #(.RADIX_BITS(RADIX_BITS), .MAX_TUPLES(MAX_TUPLES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .stat_o    (stat),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .rsp       (rsp_o)
  );

endmodule

[sim/rhp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rhp_checker
// Watches the request, result and APB traffic of the radix partitioner. It
// keeps its own copy of the store, the bucket histogram and the slot
// pointers, predicts one result per accepted request and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rhp_checker import rhp_pkg::*; #(
  parameter int unsigned RADIX_BITS = 6,
  parameter int unsigned MAX_TUPLES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [CFG_DATA_W-1:0] pwdata_i,
  rhp_req_if                    req_mon,
  rhp_rsp_if                    rsp_mon,
  output int unsigned           mismatch_count_o,
  output int unsigned           outstanding_o,
  output int unsigned           placed_count_o
);

  localparam int unsigned FANOUT = 1 << RADIX_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_TUPLES + 1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [DEST_W-1:0]   dest;
    logic [BKT_W-1:0]    bucket;
    logic                last;
  } outcome_t;

  logic [KEY_W+PAY_W-1:0] tuple_mem [MAX_TUPLES];
  logic [CNT_W-1:0]       bucket_cnt [FANOUT];
  logic [DEST_W-1:0]      slot_ptr [FANOUT];
  logic [CNT_W-1:0]       tuples_held;
  logic [CNT_W-1:0]       emit_idx;
  logic                   emitting;
  logic [SHIFT_W-1:0]     cfg_shift;
  logic [PAD_W-1:0]       cfg_pad;
  outcome_t               outcome_q [$];
  int unsigned            mismatches;
  int unsigned            placed;

  // bucket of a key under the current shift; key - 1 wraps at 32 bits
  function automatic logic [RADIX_BITS-1:0] radix_of(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] km1;
    km1 = k - 32'd1;
    return RADIX_BITS'(km1 >> cfg_shift);
  endfunction

  task automatic partition_request(input  logic             rt,
                                   input  logic [KEY_W-1:0] k,
                                   input  logic [PAY_W-1:0] p,
                                   output outcome_t         o);
    int unsigned            base;
    logic [KEY_W+PAY_W-1:0] t;
    logic [RADIX_BITS-1:0]  b;
    o = '0;
    if (rt == REQ_LOAD) begin
      if (emitting || tuples_held >= MAX_TUPLES) begin
        o.status = ST_DROPPED;
      end else begin
        tuple_mem[tuples_held] = {k, p};
        b = radix_of(k);
        bucket_cnt[b] = bucket_cnt[b] + CNT_W'(1);
        tuples_held = tuples_held + CNT_W'(1);
        o.status = ST_LOADED;
      end
    end else if (tuples_held == 0) begin
      o.status = ST_EMPTY;
    end else begin
      if (!emitting) begin
        // histogram to exclusive offsets, plus padding per partition
        base = 0;
        for (int i = 0; i < FANOUT; i++) begin
          slot_ptr[i] = DEST_W'(base + i * cfg_pad);
          base += 32'(bucket_cnt[i]);
        end
        emitting = 1'b1;
        emit_idx = '0;
      end
      t = tuple_mem[emit_idx];
      b = radix_of(t[KEY_W+PAY_W-1:PAY_W]);
      o.status  = ST_PLACED;
      o.key     = t[KEY_W+PAY_W-1:PAY_W];
      o.payload = t[PAY_W-1:0];
      o.dest    = slot_ptr[b];
      o.bucket  = BKT_W'(b);
      o.last    = ((emit_idx + CNT_W'(1)) >= tuples_held);
      slot_ptr[b] = slot_ptr[b] + DEST_W'(1);
      if (o.last) begin
        for (int i = 0; i < FANOUT; i++) begin
          bucket_cnt[i] = '0;
          slot_ptr[i]   = '0;
        end
        tuples_held = '0;
        emit_idx    = '0;
        emitting    = 1'b0;
      end else begin
        emit_idx = emit_idx + CNT_W'(1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    outcome_t predicted;
    if (!rst_ni) begin
      for (int i = 0; i < FANOUT; i++) begin
        bucket_cnt[i] = '0;
        slot_ptr[i]   = '0;
      end
      tuples_held = '0;
      emit_idx    = '0;
      emitting    = 1'b0;
      cfg_shift   = '0;
      cfg_pad     = '0;
      mismatches  = 0;
      placed      = 0;
      outcome_q.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
      placed_count_o   <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_SHIFT) cfg_shift = pwdata_i[SHIFT_W-1:0];
        else                         cfg_pad   = pwdata_i[PAD_W-1:0];
      end
      if (req_mon.valid && req_mon.ready) begin
        partition_request(req_mon.req_type, req_mon.key, req_mon.payload, predicted);
        outcome_q.push_back(predicted);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t ns: result with nothing outstanding, expected none, actual status %0d",
                   $time, rsp_mon.status);
          mismatches++;
        end else begin
          predicted = outcome_q.pop_front();
          check_field("status", predicted.status, rsp_mon.status);
          check_field("out_key", predicted.key, rsp_mon.out_key);
          check_field("out_payload", predicted.payload, rsp_mon.out_payload);
          check_field("dest_index", predicted.dest, rsp_mon.dest_index);
          check_field("bucket", predicted.bucket, rsp_mon.bucket);
          check_field("last", predicted.last, rsp_mon.last);
          if (predicted.status == ST_PLACED) placed++;
        end
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= outcome_q.size();
      placed_count_o   <= placed;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the radix partitioner with directed and random batches of loads
// and emits under bursty input and a stalling result side, reprograms the
// shift and padding registers between phases, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import rhp_pkg::*;

  localparam int unsigned RADIX_BITS   = 6;
  localparam int unsigned MAX_TUPLES   = 1024;
  localparam int unsigned RANDOM_ITEMS = 580;
  localparam int unsigned HOLD_LOADS   = 48;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SHIFT = {REG_SHIFT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_PAD   = {REG_PAD, 2'b00};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rhp_req_if req_ch ();
  rhp_rsp_if rsp_ch ();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned placed_count;
  int unsigned sent_count  = 0;
  int unsigned burst_left  = 0;
  int unsigned cfg_writes  = 0;
  int unsigned batches     = 0;
  logic        hold_req    = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  radix_histogram_partition_top #(
    .RADIX_BITS(RADIX_BITS),
    .MAX_TUPLES(MAX_TUPLES)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  rhp_checker #(
    .RADIX_BITS(RADIX_BITS),
    .MAX_TUPLES(MAX_TUPLES)
  ) partition_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .req_mon          (req_ch),
    .rsp_mon          (rsp_ch),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .placed_count_o   (placed_count)
  );

  // all tasks below start and end on a rising edge
  task automatic send_req(input logic rt, input logic [KEY_W-1:0] k,
                          input logic [PAY_W-1:0] p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.key      <= k;
    req_ch.payload  <= p;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_count++;
  endtask

  // waits on the clock first, so the checker has counted the last transaction
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_config(input int unsigned shift, input int unsigned pad);
    write_reg(ADDR_SHIFT, CFG_DATA_W'(shift));
    write_reg(ADDR_PAD, CFG_DATA_W'(pad));
  endtask

  function automatic int unsigned pick_extreme(input int unsigned max);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return max;
      default: return $urandom_range(0, max);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_key(input int unsigned mode);
    case (mode)
      0:       return $urandom();
      1:       return KEY_W'($urandom_range(0, 3));
      2:       return ($urandom_range(0, 1) != 0) ? KEY_W'($urandom_range(0, 16))
                                                 : 32'hFFFF_FFFF - $urandom_range(0, 16);
      default: return {8'($urandom_range(0, 255)), 24'h0} | KEY_W'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic run_batch();
    int unsigned n;
    int unsigned key_mode;
    batches++;
    if ($urandom_range(0, 3) == 0) begin
      wait_idle();
      set_config(pick_extreme(31), pick_extreme(255));
    end
    key_mode = $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) begin
      // noise: loads and emits mixed at random
      repeat ($urandom_range(5, 30)) begin
        send_req(1'($urandom_range(0, 1)), rand_key(key_mode), $urandom());
      end
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
      repeat (n) send_req(REQ_LOAD, rand_key(key_mode), $urandom());
      if ($urandom_range(0, 4) == 0) begin
        // register change between the loads and the first emit
        wait_idle();
        set_config(pick_extreme(31), pick_extreme(255));
      end
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) send_req(REQ_LOAD, $urandom(), $urandom());
        send_req(REQ_EMIT, $urandom(), $urandom());
      end
      if ($urandom_range(0, 5) == 0) send_req(REQ_EMIT, $urandom(), $urandom());
    end
  endtask

  // result side: stretches of steady, random and periodic stalls
  initial begin : result_sink
    int unsigned mode;
    int unsigned period;
    int unsigned phase_cnt;
    logic        hold_done;
    rsp_ch.ready <= 1'b0;
    phase_cnt = 0;
    hold_done = 1'b0;
    forever begin
      mode   = $urandom_range(0, 3);
      period = $urandom_range(2, 9);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk_i);
        if (hold_req && !hold_done) begin
          rsp_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ch.ready <= (phase_cnt % period) != 0;
          endcase
          phase_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    rst_ni          = 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.req_type <= REQ_LOAD;
    req_ch.key     <= '0;
    req_ch.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty emit, key extremes, wrap of key 0
    set_config(0, 0);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    send_req(REQ_LOAD, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_LOAD, 32'h0000_0001, 32'hFFFF_FFFF);
    send_req(REQ_LOAD, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_req(REQ_LOAD, 32'h8000_0000, 32'h5A5A_5A5A);
    send_req(REQ_LOAD, 32'h0000_0041, 32'h0000_0001);
    // shift and padding change mid batch, bucket is recomputed on emit
    wait_idle();
    set_config(31, 255);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    send_req(REQ_LOAD, 32'h1234_5678, 32'h9ABC_DEF0);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    send_req(REQ_EMIT, 32'h0, 32'h0);
    wait_idle();
    set_config(26, 0);
    send_req(REQ_LOAD, 32'h0000_0000, 32'h0000_0011);
    send_req(REQ_LOAD, 32'hFC00_0001, 32'h0000_0022);
    send_req(REQ_LOAD, 32'h0400_0001, 32'h0000_0033);
    send_req(REQ_LOAD, 32'h0000_0000, 32'h0000_0044);
    repeat (4) send_req(REQ_EMIT, 32'h0, 32'h0);

    // long result hold-off while a batch streams in, so the queue backs up
    wait_idle();
    set_config($urandom_range(0, 26), 255);
    hold_req = 1'b1;
    send_req(REQ_LOAD, 32'h0, $urandom());
    repeat (HOLD_LOADS - 1) send_req(REQ_LOAD, $urandom(), $urandom());
    repeat (HOLD_LOADS + 1) send_req(REQ_EMIT, $urandom(), $urandom());

    random_start = sent_count;
    while (sent_count - random_start < RANDOM_ITEMS) run_batch();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Issued %0d requests (%0d random batches), checked %0d placed tuples,",
             sent_count, batches, placed_count);
    $display("with %0d register writes, mid-batch changes and a long result stall.",
             cfg_writes);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("radix_histogram_partition_top test passed");
    end else begin
      $display("radix_histogram_partition_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("radix_histogram_partition_top test failed");
    $finish;
  end

endmodule
